// ===== rtl/hei_pkg.sv =====
// Package: shared types, widths, bit placement and parity for the Hamming encoder.
`default_nettype none
package hei_pkg;

   localparam int DATA_W   = 57;
   localparam int LEN_W    = 6;
   localparam int CW_W     = 63;
   localparam int PAR_W    = 3;
   localparam int MAX_PAR  = 6;

   // Input item
   typedef struct packed {
      logic [DATA_W-1:0] data_word;
      logic [LEN_W-1:0]  data_length;
      logic [LEN_W-1:0]  flip_position;
   } req_type;

   // Result item
   typedef struct packed {
      logic [CW_W-1:0]  codeword;
      logic [LEN_W-1:0] codeword_length;
      logic [PAR_W-1:0] parity_count;
   } rsp_type;

   // After length decode: message masked to its length
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  cw_len;
      logic [PAR_W-1:0]  par_cnt;
      logic [LEN_W-1:0]  flip;
   } prep_type;

   // After encoding: codeword before error injection
   typedef struct packed {
      rsp_type          rsp;
      logic [LEN_W-1:0] flip;
   } enc_type;

   // Data bit i lands on the (i+1)-th non-power-of-two position counted
   // from position 1 upward, whatever the message length.
   function automatic logic [CW_W-1:0] scatter(input logic [DATA_W-1:0] data);
      logic [CW_W-1:0] cw;
      int              k;
      cw = '0;
      k  = 0;
      for (int pos = 1; pos <= CW_W; pos++) begin
         if ((pos & (pos - 1)) != 0) begin
            cw[pos-1] = data[k];
            k++;
         end
      end
      return cw;
   endfunction

   // Even parity bit j covers every position with bit j set.
   function automatic logic [CW_W-1:0] add_parity(input logic [CW_W-1:0] cw);
      logic [CW_W-1:0] res;
      logic            par;
      res = cw;
      for (int j = 0; j < MAX_PAR; j++) begin
         par = 1'b0;
         for (int pos = 1; pos <= CW_W; pos++) begin
            if ((pos & (1 << j)) != 0) par ^= cw[pos-1];
         end
         res[(1 << j) - 1] = par;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hei_prep.sv =====
// Stage 1: clamps the message length, finds parity count and codeword length, masks data.
`default_nettype none
module hei_prep #(
   parameter int MAX_DATA_BITS = 57
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire hei_pkg::req_type in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      hei_pkg::prep_type out_data
);
   import hei_pkg::*;

   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_DATA_BITS);

   logic              valid_ff;
   prep_type          data_ff;
   prep_type          data_in;
   logic [LEN_W-1:0]  m;
   logic [PAR_W-1:0]  r;

   assign in_ready = !valid_ff || out_ready;

   // Length decode: smallest r with 2^r - r - 1 >= m
   always_comb begin
      m = in_data.data_length;
      if (m == '0) m = LEN_W'(1);
      if (m > MaxLen) m = MaxLen;
      r = PAR_W'(MAX_PAR);
      for (int t = MAX_PAR; t >= 1; t--) begin
         if (((7'd1 << t) - 7'(t) - 7'd1) >= {1'b0, m}) r = PAR_W'(t);
      end
      data_in.data    = in_data.data_word & ~({DATA_W{1'b1}} << m);
      data_in.cw_len  = m + LEN_W'(r);
      data_in.par_cnt = r;
      data_in.flip    = in_data.flip_position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/hei_encode.sv =====
// Stage 2: places message bits and computes the parity bits.
`default_nettype none
module hei_encode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire hei_pkg::prep_type in_data,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      hei_pkg::enc_type  out_data
);
   import hei_pkg::*;

   logic    valid_ff;
   enc_type data_ff;
   enc_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // Parity above the codeword length comes out zero, so no per-length gating
   always_comb begin
      data_in.rsp.codeword        = add_parity(scatter(in_data.data));
      data_in.rsp.codeword_length = in_data.cw_len;
      data_in.rsp.parity_count    = in_data.par_cnt;
      data_in.flip                = in_data.flip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/hei_inject.sv =====
// Stage 3: optional single-bit error injection and the result register.
`default_nettype none
module hei_inject (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire hei_pkg::enc_type in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      hei_pkg::rsp_type out_data
);
   import hei_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // Flip position counts from the leftmost codeword bit; zero or past the end means none
   always_comb begin
      data_in = in_data.rsp;
      if (in_data.flip != '0 && in_data.flip <= in_data.rsp.codeword_length) begin
         data_in.codeword = in_data.rsp.codeword ^
            (CW_W'(1) << (in_data.rsp.codeword_length - in_data.flip));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/hamming_encoder_error_inject_core.sv =====
// Top level: Hamming encoder with single-bit error injection, three-stage pipeline.
//
// Usage:
//   req_ channel carries one item: a message word, its length in bits and an
//   optional position (from the left, 1-based) of a bit to invert afterward.
//   rsp_ channel returns one item per request: the right-aligned codeword,
//   its length and the number of parity bits.
// Stages: length decode, encode, injection/output register, registered in
//   that order between request accept and response valid.
// Throughput: one item per cycle unless the output stalls; each stage holds
//   one item with its valid bit and advances when empty or the next stage moves.
// Stall: when rsp_ready is low the output register holds its item; the
//   pipeline keeps filling until all three stages are full, then req_ready
//   drops. Nothing is lost or repeated.
// Reset: synchronous, clears all valid bits; no item is in flight afterward.
`default_nettype none
module hamming_encoder_error_inject_core #(
   parameter int MAX_DATA_BITS = 57
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire hei_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      hei_pkg::rsp_type rsp_data
);
   import hei_pkg::*;

   logic     prep_valid;
   logic     prep_ready;
   prep_type prep_data;
   logic     enc_valid;
   logic     enc_ready;
   enc_type  enc_data;

   // Stage 1: length decode
   hei_prep #(
      .MAX_DATA_BITS(MAX_DATA_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   // Stage 2: bit placement and parity
   hei_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (enc_valid),
      .out_ready (enc_ready),
      .out_data  (enc_data)
   );

   // Stage 3: error injection, output register
   hei_inject u_inject (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (enc_valid),
      .in_ready  (enc_ready),
      .in_data   (enc_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/hei_checker.sv =====
// Checker: port-level assertions for the Hamming encoder core, and its bind.
`default_nettype none
module hei_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire hei_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire hei_pkg::rsp_type rsp_data
);
   import hei_pkg::*;

   // An offered input item holds until accepted
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input item changed while waiting");

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Parity count fits the codeword length: 2^r >= n + 1, message at least one bit
   a_par_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((7'd1 << rsp_data.parity_count) >= (7'(rsp_data.codeword_length) + 7'd1))
                 && (rsp_data.codeword_length > LEN_W'(rsp_data.parity_count)))
      else $error("parity count does not match codeword length");

   // No codeword bits above the codeword length
   a_cw_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.codeword >> rsp_data.codeword_length) == '0)
      else $error("codeword bits set above its length");

endmodule

bind hamming_encoder_error_inject_core hei_checker u_hei_checker (.*);
`default_nettype wire

// ===== dv/hamming_encoder_error_inject_core_test.sv =====
// Testbench for the Hamming encoder with error injection: table, random and backpressure items.
module hamming_encoder_error_inject_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hei_pkg::*;

   localparam int  HOLD_CYCLES = 64;
   localparam int  MAX_REPORTS = 20;
   localparam time RUN_LIMIT   = 4_000_000;

   // One row of the directed table; typed_ok marks a hand-written codeword
   typedef struct packed {
      req_type req;
      logic    typed_ok;
      rsp_type rsp;
   } table_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Hand-written codeword travelling with the item on offer
   logic    typed_valid;
   rsp_type typed_value;

   rsp_type       pending_codewords[$];
   table_row_type directed_rows[$];

   int  error_count    = 0;
   int  items_accepted = 0;
   int  words_checked  = 0;
   int  input_stalls   = 0;
   bit  hold_rsp       = 1'b0;
   bit  rsp_steady     = 1'b0;

   hamming_encoder_error_inject_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Expected codeword: parity at power-of-two positions, message MSB highest
   function automatic rsp_type hamming_encode(input req_type item);
      rsp_type         res;
      int              msg_len;
      int              par_cnt;
      int              cw_len;
      int              k;
      int              flip;
      logic [DATA_W-1:0] msg;
      logic [CW_W-1:0]   cw;
      logic            par;
      msg_len = item.data_length;
      if (msg_len < 1) msg_len = 1;
      if (msg_len > DATA_W) msg_len = DATA_W;
      par_cnt = 0;
      while ((1 << par_cnt) < msg_len + par_cnt + 1) par_cnt++;
      cw_len = msg_len + par_cnt;
      msg = item.data_word;
      for (int i = 0; i < DATA_W; i++) begin
         if (i >= msg_len) msg[i] = 1'b0;
      end
      // message bits, top first, into the non-power-of-two slots
      cw = '0;
      k  = msg_len;
      for (int pos = cw_len; pos >= 1; pos--) begin
         if ((pos & (pos - 1)) != 0) begin
            k--;
            cw[pos-1] = msg[k];
         end
      end
      for (int j = 0; j < par_cnt; j++) begin
         par = 1'b0;
         for (int pos = 1; pos <= cw_len; pos++) begin
            if ((pos & (1 << j)) != 0) par ^= cw[pos-1];
         end
         cw[(1 << j) - 1] = par;
      end
      // injected error, counted from the left end of the codeword
      flip = item.flip_position;
      if (flip >= 1 && flip <= cw_len) cw[cw_len-flip] = ~cw[cw_len-flip];
      res.codeword        = cw;
      res.codeword_length = LEN_W'(cw_len);
      res.parity_count    = PAR_W'(par_cnt);
      return res;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_cycles();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return 0;
      if (sel < 85) return $urandom_range(3, 1);
      if (sel < 97) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic req_type random_request();
      req_type     item;
      rsp_type     enc;
      logic [63:0] raw;
      int          sel;
      int          cw_len;
      raw = {$urandom(), $urandom()};
      item.data_word = raw[DATA_W-1:0];
      sel = $urandom_range(99);
      if (sel < 4) item.data_word = '0;
      else if (sel < 8) item.data_word = '1;
      sel = $urandom_range(99);
      if (sel < 78) item.data_length = LEN_W'($urandom_range(DATA_W, 1));
      else if (sel < 88) item.data_length = ($urandom_range(1)) ? LEN_W'(DATA_W) : LEN_W'(1);
      else if (sel < 93) item.data_length = '0;
      else item.data_length = LEN_W'($urandom_range(63, DATA_W + 1));
      item.flip_position = '0;
      enc    = hamming_encode(item);
      cw_len = enc.codeword_length;
      sel = $urandom_range(99);
      if (sel < 15) item.flip_position = '0;
      else if (sel < 30) item.flip_position = LEN_W'($urandom_range(63));
      else item.flip_position = LEN_W'($urandom_range(cw_len, 1));
      return item;
   endfunction

   function automatic void add_row(input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len,
                                   input logic [LEN_W-1:0] flip, input logic typed_ok,
                                   input logic [CW_W-1:0] cw, input logic [LEN_W-1:0] cw_len,
                                   input logic [PAR_W-1:0] par_cnt);
      table_row_type row;
      row.req.data_word          = data;
      row.req.data_length        = len;
      row.req.flip_position      = flip;
      row.typed_ok               = typed_ok;
      row.rsp.codeword           = cw;
      row.rsp.codeword_length    = cw_len;
      row.rsp.parity_count       = par_cnt;
      directed_rows.push_back(row);
   endfunction

   // Offer one item after an optional gap and hold it until accepted
   task automatic send_item(input req_type item, input logic typed_ok,
                            input rsp_type typed_rsp, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= item;
      typed_valid <= typed_ok;
      typed_value <= typed_rsp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(input int count, input bit no_gaps);
      for (int i = 0; i < count; i++) begin
         send_item(random_request(), 1'b0, '0, no_gaps ? 0 : idle_cycles());
      end
   endtask

   task automatic drain_pause();
      req_valid <= 1'b0;
      while (pending_codewords.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both channels are sampled at the edge; items in before results out
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_codewords.push_back(typed_valid ? typed_value : hamming_encode(req_data));
            items_accepted++;
         end
         if (req_valid && !req_ready) input_stalls++;
         if (rsp_valid && rsp_ready) begin
            if (pending_codewords.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: result with nothing expected, codeword %h", $time,
                           rsp_data.codeword);
            end else begin
               want = pending_codewords.pop_front();
               words_checked++;
               if (rsp_data.codeword !== want.codeword) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: codeword expected %h actual %h", $time,
                              want.codeword, rsp_data.codeword);
               end
               if (rsp_data.codeword_length !== want.codeword_length) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: codeword_length expected %0d actual %0d", $time,
                              want.codeword_length, rsp_data.codeword_length);
               end
               if (rsp_data.parity_count !== want.parity_count) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: parity_count expected %0d actual %0d", $time,
                              want.parity_count, rsp_data.parity_count);
               end
            end
         end
      end
   end

   // Result side: random stalls, a steady mode and one long hold-off
   initial begin : rsp_side
      int idle;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_steady) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            idle = idle_cycles();
            if (idle > 0) begin
               rsp_ready <= 1'b0;
               repeat (idle) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("%0t: run limit reached, %0d results still due", $time,
               pending_codewords.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin : req_side
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      typed_valid <= 1'b0;
      typed_value <= '0;

      // single message bit: codeword 3 bits, 2 parity bits
      add_row(57'd1, 6'd1, 6'd0, 1'b1, 63'h7, 6'd3, 3'd2);
      add_row(57'd0, 6'd1, 6'd0, 1'b1, 63'h0, 6'd3, 3'd2);
      // length zero behaves as length one
      add_row(57'd1, 6'd0, 6'd0, 1'b1, 63'h7, 6'd3, 3'd2);
      add_row(57'd1, 6'd1, 6'd1, 1'b1, 63'h3, 6'd3, 3'd2);
      add_row(57'd1, 6'd1, 6'd3, 1'b1, 63'h6, 6'd3, 3'd2);
      // flip beyond the codeword is ignored
      add_row(57'd1, 6'd1, 6'd4, 1'b1, 63'h7, 6'd3, 3'd2);
      add_row(57'd1, 6'd1, 6'd63, 1'b1, 63'h7, 6'd3, 3'd2);
      // bits above the message length are ignored
      add_row({DATA_W{1'b1}}, 6'd1, 6'd0, 1'b1, 63'h7, 6'd3, 3'd2);
      // full-width message: 63-bit codeword
      add_row({DATA_W{1'b1}}, 6'd57, 6'd0, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 6'd63, 3'd6);
      add_row(57'd0, 6'd57, 6'd0, 1'b1, 63'h0, 6'd63, 3'd6);
      add_row({DATA_W{1'b1}}, 6'd57, 6'd63, 1'b1, 63'h7FFF_FFFF_FFFF_FFFE, 6'd63, 3'd6);
      add_row({DATA_W{1'b1}}, 6'd57, 6'd1, 1'b1, 63'h3FFF_FFFF_FFFF_FFFF, 6'd63, 3'd6);
      // lengths above the maximum saturate
      add_row({DATA_W{1'b1}}, 6'd58, 6'd0, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 6'd63, 3'd6);
      add_row({DATA_W{1'b1}}, 6'd63, 6'd0, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 6'd63, 3'd6);
      // parity-count boundaries and mixed patterns
      add_row(57'hB, 6'd4, 6'd0, 1'b0, '0, '0, '0);
      add_row(57'h2, 6'd2, 6'd2, 1'b0, '0, '0, '0);
      add_row(57'h5, 6'd3, 6'd5, 1'b0, '0, '0, '0);
      add_row(57'h16, 6'd5, 6'd0, 1'b0, '0, '0, '0);
      add_row(57'h5A5, 6'd11, 6'd15, 1'b0, '0, '0, '0);
      add_row(57'hC3C, 6'd12, 6'd9, 1'b0, '0, '0, '0);
      add_row(57'h2AA_AAAA, 6'd26, 6'd31, 1'b0, '0, '0, '0);
      add_row(57'h555_5555, 6'd27, 6'd33, 1'b0, '0, '0, '0);
      add_row(57'h0AA_AAAA_AAAA_AAAA, 6'd56, 6'd62, 1'b0, '0, '0, '0);
      add_row(57'h155_5555_5555_5555, 6'd57, 6'd32, 1'b0, '0, '0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed_ok, directed_rows[i].rsp,
                   idle_cycles());
      drain_pause();

      // random items with idling on both sides
      send_random(400, 1'b0);
      drain_pause();

      // output held off while input is offered back to back
      hold_rsp = 1'b1;
      send_random(40, 1'b1);
      drain_pause();

      // full rate on both sides
      rsp_steady = 1'b1;
      send_random(150, 1'b1);
      drain_pause();
      rsp_steady = 1'b0;

      send_random(340, 1'b0);
      drain_pause();
      repeat (10) @(posedge clock);

      $display("Covered %0d items (%0d from the directed table), %0d codewords checked,",
               items_accepted, directed_rows.size(), words_checked);
      $display("  with %0d input stall cycles under output backpressure", input_stalls);
      if (error_count == 0 && pending_codewords.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
